// ===== hdl/asmas_pkg.sv =====
package asmas_pkg;

  localparam int NUM_CH       = 3;
  localparam int SAMPLE_W     = 10;
  localparam int LOW_W        = 8;
  localparam int HIGH_W       = 2;
  localparam int CH_W         = 2;
  localparam int GAIN_W       = 16;
  localparam int VALUE_W      = 16;
  localparam int Q_SHIFT      = 11;
  localparam int LAST_CUR_W   = 13;
  localparam int LAST_CUR_MAX = 8191;
  localparam int CFG_IDX_W    = 2;

  localparam int WINDOW_SAMPLES_DEF = 16;

  localparam logic [GAIN_W-1:0] REF_GAIN_RST   = 16'd40167;
  localparam logic [GAIN_W-1:0] CUR_GAIN_RST   = 16'd10025;
  localparam logic [GAIN_W-1:0] VOLT_GAIN_RST  = 16'd40167;
  localparam logic [GAIN_W-1:0] SHUNT_GAIN_RST = 16'd451;

  // scan channels
  typedef enum logic [CH_W-1:0] {
    CH_REF  = 2'd0,
    CH_CUR  = 2'd1,
    CH_VOLT = 2'd2
  } chan_t;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_GAIN   = 2'd0,
    REG_CUR_GAIN   = 2'd1,
    REG_VOLT_GAIN  = 2'd2,
    REG_SHUNT_GAIN = 2'd3
  } cfg_reg_t;

endpackage

// ===== hdl/asmas_ram.sv =====
module asmas_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 48,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/adc_scan_moving_average_scaler_unit.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     in_sample_low[7:0], in_sample_high[1:0]
// out      output     out_valid / out_ready   out_channel[1:0], out_scaled_value[15:0] (signed),
//                                             out_next_channel[1:0]
// cfg      input      cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[15:0]
//
// Throughput: one item per cycle while the output is not stalled.
// The figure is set by the sample-RAM read-modify-write stage, which retires one item per cycle.
// Reset (rst_n low, synchronous) empties the pipeline and restores the gains. No clearing
// pass: a fill flag stands in for the zeroed sample store until the window wraps once.
// A stalled output (out_valid high, out_ready low) freezes every stage, and in_ready drops.
// cfg_ready is always high.
module adc_scan_moving_average_scaler_unit
  import asmas_pkg::*;
#(
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [LOW_W-1:0]          in_sample_low,
  input  logic [HIGH_W-1:0]         in_sample_high,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CH_W-1:0]           out_channel,
  output logic signed [VALUE_W-1:0] out_scaled_value,
  output logic [CH_W-1:0]           out_next_channel,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [GAIN_W-1:0]         cfg_data
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int POS_W   = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int DEPTH   = NUM_CH * WINDOW_SAMPLES;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W   = $clog2(WINDOW_SAMPLES * ((1 << SAMPLE_W) - 1) + 1);
  localparam int SADDR_W = $clog2(NUM_CH);
  localparam int QP_W    = 2 * SUM_W + 1;
  localparam int PROD_W  = SAMPLE_W + GAIN_W;
  localparam int SHP_W   = LAST_CUR_W + GAIN_W;
  localparam int DIFF_W  = ((PROD_W > SHP_W) ? PROD_W : SHP_W) + 1;
  localparam int QUO_W   = DIFF_W - Q_SHIFT;
  localparam int CURV_W  = PROD_W - Q_SHIFT;

  // Reciprocal of the window length: floor(sum * RECIP / 2^SUM_W) is the
  // quotient or one less, fixed by a single compare afterwards.
  localparam logic [SUM_W:0] RECIP = (SUM_W+1)'((1 << SUM_W) / WINDOW_SAMPLES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0] ref_gain_r, cur_gain_r, volt_gain_r, shunt_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_gain_r   <= REF_GAIN_RST;
      cur_gain_r   <= CUR_GAIN_RST;
      volt_gain_r  <= VOLT_GAIN_RST;
      shunt_gain_r <= SHUNT_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REF_GAIN:   ref_gain_r   <= cfg_data;
        REG_CUR_GAIN:   cur_gain_r   <= cfg_data;
        REG_VOLT_GAIN:  volt_gain_r  <= cfg_data;
        REG_SHUNT_GAIN: shunt_gain_r <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a full stall when the result register is held
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  logic accept;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Scan state: channel, window position, fill flag
  // ---------------------------------------------------------------------------
  chan_t             ch_r, ch_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              wrapped_r, wrapped_nxt;   // every slot written at least once
  logic [NUM_CH-1:0] sum_vld_r;                // channel sum written at least once
  logic [ADDR_W-1:0] rd_slot;

  always_comb begin
    ch_nxt      = ch_r;
    pos_nxt     = pos_r;
    wrapped_nxt = wrapped_r;
    if (accept) begin
      unique case (ch_r)
        CH_REF:  ch_nxt = CH_CUR;
        CH_CUR:  ch_nxt = CH_VOLT;
        default: begin
          ch_nxt = CH_REF;
          if (pos_r == POS_W'(WINDOW_SAMPLES - 1)) begin
            pos_nxt     = '0;
            wrapped_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      endcase
    end
  end

  assign rd_slot = ADDR_W'(32'(ch_r) * WINDOW_SAMPLES + 32'(pos_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r      <= CH_REF;
      pos_r     <= '0;
      wrapped_r <= 1'b0;
    end else begin
      ch_r      <= ch_nxt;
      pos_r     <= pos_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: memory read data arrives; read-modify-write of sample and sum
  // ---------------------------------------------------------------------------
  logic              v1_r, ovld1_r, svld1_r;
  chan_t             ch1_r, nch1_r;
  logic [SAMPLE_W-1:0] smp1_r;
  logic [ADDR_W-1:0] slot1_r;

  logic [SAMPLE_W-1:0] smp_rdata, smp_old;
  logic [SUM_W-1:0]    sum_rdata, sum_old, sum_new;
  logic                wr_en;

  assign wr_en   = v1_r && adv;
  assign smp_old = ovld1_r ? smp_rdata : '0;
  assign sum_old = svld1_r ? sum_rdata : '0;
  assign sum_new = sum_old - SUM_W'(smp_old) + SUM_W'(smp1_r);

  asmas_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot1_r),
    .wdata (smp1_r),
    .re    (accept),
    .raddr (rd_slot),
    .rdata (smp_rdata)
  );

  asmas_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_CH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (SADDR_W'(ch1_r)),
    .wdata (sum_new),
    .re    (accept),
    .raddr (SADDR_W'(ch_r)),
    .rdata (sum_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= '0;
    end else if (wr_en) begin
      sum_vld_r[ch1_r] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2..7: divide by window length, scale, shunt correction
  // ---------------------------------------------------------------------------
  logic v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  chan_t ch2_r, ch3_r, ch4_r, ch5_r, ch6_r, ch7_r;
  chan_t nch2_r, nch3_r, nch4_r, nch5_r, nch6_r, nch7_r;

  logic [SUM_W-1:0]    sum2_r, sum3_r, qe3_r;
  logic [SAMPLE_W-1:0] avg4_r;
  logic [PROD_W-1:0]   prod5_r, prod6_r, prod7_r;
  logic [SHP_W-1:0]    shp7_r;
  logic [LAST_CUR_W-1:0] last_cur_r;

  logic [QP_W-1:0]   qp;
  logic [SUM_W-1:0]  qn, rem;
  logic [SAMPLE_W-1:0] avg;
  logic [GAIN_W-1:0] gain_sel;
  logic [CURV_W-1:0] cur_val;
  logic [SHP_W-1:0]  shp;

  assign qp  = QP_W'(sum2_r) * QP_W'(RECIP);
  assign qn  = SUM_W'(32'(qe3_r) * WINDOW_SAMPLES);
  assign rem = sum3_r - qn;
  assign avg = (rem >= SUM_W'(WINDOW_SAMPLES)) ? SAMPLE_W'(qe3_r + SUM_W'(1))
                                               : SAMPLE_W'(qe3_r);

  always_comb begin
    unique case (ch4_r)
      CH_REF:  gain_sel = ref_gain_r;
      CH_CUR:  gain_sel = cur_gain_r;
      default: gain_sel = volt_gain_r;
    endcase
  end

  assign cur_val = prod5_r[PROD_W-1:Q_SHIFT];
  // last_cur_r is settled here: the current item ahead has left stage 5
  assign shp = (ch6_r == CH_VOLT) ? SHP_W'(last_cur_r) * SHP_W'(shunt_gain_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      v6_r       <= 1'b0;
      v7_r       <= 1'b0;
      last_cur_r <= '0;
    end else if (adv) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      if (v5_r && ch5_r == CH_CUR) begin
        last_cur_r <= (cur_val > CURV_W'(LAST_CUR_MAX)) ? LAST_CUR_W'(LAST_CUR_MAX)
                                                        : cur_val[LAST_CUR_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      ch1_r   <= ch_r;
      nch1_r  <= ch_nxt;
      smp1_r  <= {in_sample_high, in_sample_low};
      slot1_r <= rd_slot;
      ovld1_r <= wrapped_r;
      svld1_r <= sum_vld_r[ch_r];

      ch2_r  <= ch1_r;
      nch2_r <= nch1_r;
      sum2_r <= sum_new;

      ch3_r  <= ch2_r;
      nch3_r <= nch2_r;
      sum3_r <= sum2_r;
      qe3_r  <= qp[2*SUM_W-1 -: SUM_W];

      ch4_r  <= ch3_r;
      nch4_r <= nch3_r;
      avg4_r <= avg;

      ch5_r   <= ch4_r;
      nch5_r  <= nch4_r;
      prod5_r <= PROD_W'(avg4_r) * PROD_W'(gain_sel);

      ch6_r   <= ch5_r;
      nch6_r  <= nch5_r;
      prod6_r <= prod5_r;

      ch7_r   <= ch6_r;
      nch7_r  <= nch6_r;
      prod7_r <= prod6_r;
      shp7_r  <= shp;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7 -> result register: signed difference, truncate toward zero, clamp
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]  diff, diff_adj;
  logic signed [QUO_W-1:0]   quo;
  logic signed [VALUE_W-1:0] value;

  assign diff     = $signed(DIFF_W'(prod7_r)) - $signed(DIFF_W'(shp7_r));
  // bias negatives by 2^Q - 1 so the arithmetic shift rounds toward zero
  assign diff_adj = diff + (diff[DIFF_W-1] ? DIFF_W'((1 << Q_SHIFT) - 1) : DIFF_W'(0));
  assign quo      = QUO_W'(diff_adj >>> Q_SHIFT);

  always_comb begin
    priority if (quo < -$signed(QUO_W'(1 << (VALUE_W - 1)))) begin
      value = {1'b1, {(VALUE_W-1){1'b0}}};
    end else if (quo > $signed(QUO_W'((1 << (VALUE_W - 1)) - 1))) begin
      value = {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      value = VALUE_W'(quo);
    end
  end

  logic [CH_W-1:0]           out_channel_r, out_next_r;
  logic signed [VALUE_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_channel_r <= ch7_r;
      out_next_r    <= nch7_r;
      out_value_r   <= value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_next_channel = out_next_r;
  assign out_scaled_value = out_value_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a write-back never lands on the slot being read in the same cycle
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && accept) |-> (slot1_r != rd_slot))
    else $error("sample RAM read and write collide");

  // voltage item never overtakes the current item it depends on
  a_current_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && ch6_r == CH_VOLT) |-> !(v5_r && ch5_r == CH_CUR))
    else $error("current item behind voltage item");

  // next channel follows the scan order
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_channel_r == CH_VOLT && out_next_r == CH_REF) ||
                     (out_channel_r != CH_VOLT && out_next_r == out_channel_r + CH_W'(1))))
    else $error("next channel out of scan order");

endmodule

// ===== dv/tb_adc_scan_moving_average_scaler_unit.sv =====
`timescale 1ns / 100ps

module tb_adc_scan_moving_average_scaler_unit;
  import asmas_pkg::*;

  localparam int     WIN             = WINDOW_SAMPLES_DEF;
  localparam int     SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
  localparam longint Q_ONE           = longint'(1) << Q_SHIFT;
  localparam longint VAL_MAX         = (longint'(1) << (VALUE_W - 1)) - 1;
  localparam longint VAL_MIN         = -(longint'(1) << (VALUE_W - 1));
  localparam int     SETTLE_CYC      = 12;
  localparam int     SETTLE_GUARD    = 5000;
  localparam int     SWEEP_PHASES    = 8;
  localparam int     ITEMS_PER_PHASE = 170;
  localparam int     STALL_ITEMS     = 60;
  localparam int     STALL_HOLD      = 150;  // long receiver hold-off, in cycles
  localparam int     IDLE_MAX        = 19;

  // one result item as the block should present it
  typedef struct {
    chan_t                     channel;
    logic signed [VALUE_W-1:0] value;
    chan_t                     next_channel;
  } scan_result_t;

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic [LOW_W-1:0]          in_sample_low    = '0;
  logic [HIGH_W-1:0]         in_sample_high   = '0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic [CH_W-1:0]           out_channel;
  logic signed [VALUE_W-1:0] out_scaled_value;
  logic [CH_W-1:0]           out_next_channel;
  logic                      cfg_valid        = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index        = '0;
  logic [GAIN_W-1:0]         cfg_data         = '0;

  // predictor state: gains, sample windows, running sums, scan position
  logic [GAIN_W-1:0]   ref_gain   = REF_GAIN_RST;
  logic [GAIN_W-1:0]   cur_gain   = CUR_GAIN_RST;
  logic [GAIN_W-1:0]   volt_gain  = VOLT_GAIN_RST;
  logic [GAIN_W-1:0]   shunt_gain = SHUNT_GAIN_RST;
  logic [SAMPLE_W-1:0] win_store [NUM_CH * WIN];
  int                  win_sum   [NUM_CH];
  chan_t               scan_ch    = CH_REF;
  int                  win_pos    = 0;
  int                  last_cur   = 0;

  scan_result_t expected_readings [$];
  int unsigned  mismatch_cnt = 0;

  // idle shaping, changed per burst by the tests
  int unsigned gap_max   = IDLE_MAX;
  int unsigned stall_max = IDLE_MAX;
  int unsigned hold_len  = 0;

  always #1 clk = ~clk;

  adc_scan_moving_average_scaler_unit #(
    .WINDOW_SAMPLES(WIN)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_low   (in_sample_low),
    .in_sample_high  (in_sample_high),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_scaled_value(out_scaled_value),
    .out_next_channel(out_next_channel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    foreach (win_store[i]) win_store[i] = '0;
    foreach (win_sum[i]) win_sum[i] = 0;
  end

  // Advance the predictor by one conversion and return the expected item.
  function automatic scan_result_t average_and_scale(logic [LOW_W-1:0] lo,
                                                     logic [HIGH_W-1:0] hi);
    logic [SAMPLE_W-1:0] smp;
    int                  slot_i;
    longint              avg;
    longint              acc;
    scan_result_t        res;
    smp    = {hi, lo};
    slot_i = int'(scan_ch) * WIN + win_pos;
    // new sample replaces the oldest one of this channel; sum follows
    win_sum[scan_ch]  = win_sum[scan_ch] - int'(win_store[slot_i]) + int'(smp);
    win_store[slot_i] = smp;
    avg = win_sum[scan_ch] / WIN;
    case (scan_ch)
      CH_REF: begin
        acc = (avg * longint'(ref_gain)) >>> Q_SHIFT;
      end
      CH_CUR: begin
        acc = (avg * longint'(cur_gain)) >>> Q_SHIFT;
        // full value goes out, stored copy clips
        last_cur = (acc > LAST_CUR_MAX) ? LAST_CUR_MAX : int'(acc);
      end
      default: begin
        // signed divide truncates toward zero
        acc = (avg * longint'(volt_gain) - longint'(last_cur) * longint'(shunt_gain)) / Q_ONE;
      end
    endcase
    if (acc > VAL_MAX) acc = VAL_MAX;
    if (acc < VAL_MIN) acc = VAL_MIN;
    res.channel = scan_ch;
    res.value   = acc[VALUE_W-1:0];
    case (scan_ch)
      CH_REF:  scan_ch = CH_CUR;
      CH_CUR:  scan_ch = CH_VOLT;
      default: begin
        scan_ch = CH_REF;
        win_pos = (win_pos + 1) % WIN;
      end
    endcase
    res.next_channel = scan_ch;
    return res;
  endfunction

  // Offer one item after a random gap; valid stays up after acceptance so
  // back-to-back items never drop it within a step.
  task automatic send_sample(logic [LOW_W-1:0] lo, logic [HIGH_W-1:0] hi);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_low  <= lo;
    in_sample_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_readings.push_back(average_and_scale(lo, hi));
  endtask

  // cfg_valid is left high; the caller drops it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_REF_GAIN:  ref_gain   = val;
      REG_CUR_GAIN:  cur_gain   = val;
      REG_VOLT_GAIN: volt_gain  = val;
      default:       shunt_gain = val;
    endcase
  endtask

  task automatic load_gains(logic [GAIN_W-1:0] r, logic [GAIN_W-1:0] c,
                            logic [GAIN_W-1:0] v, logic [GAIN_W-1:0] s);
    write_reg(REG_REF_GAIN, r);
    write_reg(REG_CUR_GAIN, c);
    write_reg(REG_VOLT_GAIN, v);
    write_reg(REG_SHUNT_GAIN, s);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every expected item, then let the pipe drain.
  task automatic settle_pipeline();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_readings.size() != 0 && guard < SETTLE_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
    endcase
  endfunction

  // Field extremes and alternating-bit patterns at the reset gains.
  task automatic test_field_extremes();
    send_sample(8'h00, 2'd0);
    send_sample(8'hFF, 2'd3);
    send_sample(8'hFF, 2'd0);
    send_sample(8'h00, 2'd3);
    send_sample(8'h55, 2'd1);
    send_sample(8'hAA, 2'd2);
    settle_pipeline();
  endtask

  // Full-scale current saturates the stored copy; with max shunt gain and
  // zero voltage the voltage channel clips at the negative limit.
  task automatic test_current_and_shunt_saturation();
    load_gains('1, '1, '0, '1);
    repeat (6 * NUM_CH) begin
      if (scan_ch == CH_VOLT) send_sample('0, '0);
      else                    send_sample('1, '1);
    end
    settle_pipeline();
  endtask

  // Gain settings from reset values through both extremes to random mixes.
  // Each phase is bursts of rounds where each channel follows its own
  // level: uniform, pinned at a rail, pinned at a random level or jittering.
  task automatic test_gain_sweep();
    int unsigned sent;
    int unsigned rounds;
    int          level  [NUM_CH];
    int          spread [NUM_CH];
    int          v;
    logic [SAMPLE_W-1:0] smp;
    for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
      case (ph)
        0:       load_gains(REF_GAIN_RST, CUR_GAIN_RST, VOLT_GAIN_RST, SHUNT_GAIN_RST);
        1:       load_gains('0, '0, '0, '0);
        2:       load_gains('1, '1, '1, '1);
        default: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        rounds = $urandom_range(2, 40);
        for (int c = 0; c < NUM_CH; c++) begin
          case ($urandom_range(0, 3))
            0: begin
              level[c]  = SAMPLE_MAX / 2;
              spread[c] = SAMPLE_MAX / 2 + 1;
            end
            1: begin
              level[c]  = $urandom_range(0, 1) * SAMPLE_MAX;
              spread[c] = 0;
            end
            2: begin
              level[c]  = $urandom_range(0, SAMPLE_MAX);
              spread[c] = 0;
            end
            default: begin
              level[c]  = $urandom_range(0, SAMPLE_MAX);
              spread[c] = $urandom_range(1, 64);
            end
          endcase
        end
        // idle pattern for this burst, including stretches with none
        case ($urandom_range(0, 3))
          0:       begin gap_max = 0;        stall_max = 0;        end
          1:       begin gap_max = IDLE_MAX; stall_max = 0;        end
          2:       begin gap_max = 0;        stall_max = IDLE_MAX; end
          default: begin gap_max = IDLE_MAX; stall_max = IDLE_MAX; end
        endcase
        for (int k = 0; k < rounds * NUM_CH && sent < ITEMS_PER_PHASE; k++) begin
          v = level[scan_ch] - spread[scan_ch] + int'($urandom_range(0, 2 * spread[scan_ch]));
          if (v < 0)          v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          smp = v[SAMPLE_W-1:0];
          send_sample(smp[LOW_W-1:0], smp[SAMPLE_W-1:LOW_W]);
          sent++;
        end
      end
      settle_pipeline();
    end
    gap_max   = IDLE_MAX;
    stall_max = IDLE_MAX;
  endtask

  // Receiver holds off for a long stretch while items keep coming back to
  // back, so the pipe fills and in_ready has to drop.
  task automatic test_output_stall();
    gap_max  = 0;
    hold_len = STALL_HOLD;
    repeat (STALL_ITEMS) send_sample(LOW_W'($urandom_range(0, 255)),
                                     HIGH_W'($urandom_range(0, 3)));
    settle_pipeline();
    gap_max = IDLE_MAX;
  endtask

  // Result side: random stall before each item, or the long hold-off when
  // one is requested; ready stays high while waiting for valid.
  initial begin : result_sink
    int unsigned wait_n;
    forever begin
      if (hold_len != 0) begin
        wait_n   = hold_len;
        hold_len = 0;
      end else begin
        wait_n = $urandom_range(0, stall_max);
      end
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted item against the oldest expectation.
  always @(posedge clk) begin : check_results
    scan_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected item: ch %0d value %0d next %0d",
                   out_channel, out_scaled_value, out_next_channel);
      end else begin
        exp_r = expected_readings.pop_front();
        if (out_channel !== exp_r.channel || out_scaled_value !== exp_r.value ||
            out_next_channel !== exp_r.next_channel) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp ch %0d value %0d next %0d, got ch %0d value %0d next %0d",
                     exp_r.channel, exp_r.value, exp_r.next_channel,
                     out_channel, out_scaled_value, out_next_channel);
        end
      end
    end
  end

  initial begin : run_tests
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_current_and_shunt_saturation();
    test_gain_sweep();
    test_output_stall();
    // anything still waiting never came out
    if (expected_readings.size() != 0) begin
      $display("%0d expected items never arrived", expected_readings.size());
      mismatch_cnt += expected_readings.size();
    end
    if (mismatch_cnt == 0)
      $display("[adc_scan_moving_average_scaler_unit] OK");
    else
      $display("[adc_scan_moving_average_scaler_unit] ERROR");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("[adc_scan_moving_average_scaler_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/asmas_pkg.sv
hdl/asmas_ram.sv
hdl/adc_scan_moving_average_scaler_unit.sv
dv/tb_adc_scan_moving_average_scaler_unit.sv
